>>> rtl/core/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// shared constants and types of the set associative cache lookup with lru
// ----------------------------------------------------------------------------
package sacl_pkg;

  // cache geometry, all powers of two
  localparam int unsigned SETS        = 64;
  localparam int unsigned WAYS        = 4;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned ADDR_BITS   = 32;

  // beat field widths
  localparam int unsigned IN_ADDR_W = 32;
  localparam int unsigned OUT_WAY_W = 2;
  localparam int unsigned OUT_SET_W = 6;
  localparam int unsigned CNT_W     = 32;

  localparam int unsigned OFFSET_W = $clog2(BLOCK_BYTES);
  localparam int unsigned SET_W    = $clog2(SETS);
  localparam int unsigned TAG_W    = ADDR_BITS - OFFSET_W - SET_W;
  localparam int unsigned WAY_W    = $clog2(WAYS);
  localparam int unsigned RANK_W   = $clog2(WAYS);

  typedef logic [SET_W-1:0]  set_idx_t;
  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [WAY_W-1:0]  way_t;
  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // one memory row holds a whole set
  typedef struct packed {
    logic [WAYS-1:0]             valid;
    logic [WAYS-1:0][RANK_W-1:0] rank;
    logic [WAYS-1:0][TAG_W-1:0]  tag;
  } set_row_t;

  // outcome of one lookup
  typedef struct packed {
    logic            hit;
    logic            evicted;
    way_t            way;
    logic [WAYS-1:0] match;
  } dec_t;

endpackage

>>> rtl/core/sacl_req_if.sv
// ----------------------------------------------------------------------------
// sacl_req_if
// request channel, one byte address per beat
// ----------------------------------------------------------------------------
interface sacl_req_if;
  import sacl_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [IN_ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);

endinterface

>>> rtl/core/sacl_rsp_if.sv
// ----------------------------------------------------------------------------
// sacl_rsp_if
// response channel, one lookup outcome per beat
// ----------------------------------------------------------------------------
interface sacl_rsp_if;
  import sacl_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic                 evicted;
  logic [OUT_WAY_W-1:0] way;
  logic [OUT_SET_W-1:0] set_index;
  logic [CNT_W-1:0]     hit_total;
  logic [CNT_W-1:0]     miss_total;
  logic [CNT_W-1:0]     evict_total;

  modport source (
    output valid, output hit, output evicted, output way, output set_index,
    output hit_total, output miss_total, output evict_total, input ready
  );
  modport sink (
    input valid, input hit, input evicted, input way, input set_index,
    input hit_total, input miss_total, input evict_total, output ready
  );

endinterface

>>> rtl/core/sacl_set_mem.sv
// ----------------------------------------------------------------------------
// sacl_set_mem
// set memory, one row per set, registered read, per-row init flags
// ----------------------------------------------------------------------------
module sacl_set_mem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  sacl_pkg::set_idx_t rd_set_i,
  output sacl_pkg::set_row_t rd_row_o,
  input  logic               wr_en_i,
  input  sacl_pkg::set_idx_t wr_set_i,
  input  sacl_pkg::set_row_t wr_row_i
);
  import sacl_pkg::*;

  set_row_t          mem_q [SETS];
  logic   [SETS-1:0] init_q;
  set_row_t          rd_data_q;
  logic              rd_init_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_set_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_set_i];
    end
  end

  // a row never written reads as the reset row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q    <= '0;
      rd_init_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        init_q[wr_set_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_init_q <= init_q[rd_set_i];
      end
    end
  end

  always_comb begin
    rd_row_o = rd_data_q;
    if (!rd_init_q) begin
      rd_row_o.valid = '0;
      for (int w = 0; w < WAYS; w++) begin
        rd_row_o.rank[w] = RANK_W'(w);
      end
    end
  end

endmodule

>>> rtl/core/sacl_way_sel.sv
// ----------------------------------------------------------------------------
// sacl_way_sel
// tag compare, victim choice and lru rank update for one set row
// ----------------------------------------------------------------------------
module sacl_way_sel (
  input  sacl_pkg::set_row_t row_i,
  input  sacl_pkg::tag_t     tag_i,
  output sacl_pkg::dec_t     dec_o,
  output sacl_pkg::set_row_t row_o
);
  import sacl_pkg::*;

  logic [WAYS-1:0] match;
  logic            hit;
  logic            has_free;
  way_t            hit_way;
  way_t            free_way;
  way_t            lru_way;
  way_t            use_way;
  rank_t           old_rank;

  always_comb begin
    hit_way  = '0;
    free_way = '0;
    lru_way  = '0;
    has_free = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = row_i.valid[w] && (row_i.tag[w] == tag_i);
    end
    hit = |match;
    // walk downward so the lowest way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!row_i.valid[w]) begin
        free_way = WAY_W'(w);
        has_free = 1'b1;
      end
      if (row_i.rank[w] == RANK_W'(WAYS - 1)) begin
        lru_way = WAY_W'(w);
      end
    end
    priority if (hit) begin
      use_way = hit_way;
    end else if (has_free) begin
      use_way = free_way;
    end else begin
      use_way = lru_way;
    end
  end

  always_comb begin
    old_rank = row_i.rank[use_way];
    row_o    = row_i;
    if (!hit) begin
      row_o.tag[use_way]   = tag_i;
      row_o.valid[use_way] = 1'b1;
    end
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == use_way) begin
        row_o.rank[w] = '0;
      end else if (row_i.rank[w] < old_rank) begin
        row_o.rank[w] = row_i.rank[w] + RANK_W'(1);
      end
    end
  end

  assign dec_o.hit     = hit;
  assign dec_o.evicted = !hit && !has_free;
  assign dec_o.way     = use_way;
  assign dec_o.match   = match;

endmodule

>>> rtl/core/set_assoc_cache_lru_lookup_core.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup_core
// 4-way, 64-set cache tag lookup with true lru replacement and hit counters
// ----------------------------------------------------------------------------
// usage
//   req_i carries one byte address per beat. the address splits into a block
//   offset, a set index and a tag. rsp_o returns one beat per request: hit,
//   evicted, the way hit or filled, the set index, and the saturating hit,
//   miss and eviction totals counted up to and including this access.
// timing
//   a request beat reads its set row from the set memory, whose read port is
//   registered; the way select then compares tags, picks the way, writes the
//   row back and loads the response register once that register can take it.
//   the read-modify-write of the set memory limits the request rate: a new
//   request is taken only after the previous row is written back, so no
//   forwarding is needed. response valid comes straight from the response
//   register, which is set when the row is written back.
// stalls
//   while a response waits in the output register, one more request is taken
//   and read; it holds before write-back until the response beat drains.
// reset
//   clears all valid bits and sets every lru rank to its way number at once
//   through per-set init flags, no clearing pass; the counters reset to zero.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup_core (
  input logic        clk_i,
  input logic        rst_ni,
  sacl_req_if.sink   req_i,
  sacl_rsp_if.source rsp_o
);
  import sacl_pkg::*;

  // lookup in flight, row read is pending or being updated
  logic     busy_q, busy_d;
  set_idx_t set_q;
  tag_t     tag_q;

  logic     req_beat;
  logic     commit;
  set_idx_t req_set;
  tag_t     req_tag;

  set_row_t rd_row;
  set_row_t new_row;
  dec_t     dec;

  // saturating counters
  cnt_t hit_cnt_q, hit_cnt_d;
  cnt_t miss_cnt_q, miss_cnt_d;
  cnt_t evict_cnt_q, evict_cnt_d;

  // response register
  logic     out_valid_q, out_valid_d;
  logic     out_hit_q;
  logic     out_evicted_q;
  way_t     out_way_q;
  set_idx_t out_set_q;

  // address split
  assign req_set = req_i.address[OFFSET_W +: SET_W];
  assign req_tag = req_i.address[OFFSET_W + SET_W +: TAG_W];

  // one lookup at a time, interlocks the read-modify-write of a set row
  assign req_i.ready = !busy_q;
  assign req_beat    = req_i.valid && req_i.ready;

  // write back only when the response register can take the result
  assign commit = busy_q && (!out_valid_q || rsp_o.ready);

  sacl_set_mem u_set_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (req_beat),
    .rd_set_i (req_set),
    .rd_row_o (rd_row),
    .wr_en_i  (commit),
    .wr_set_i (set_q),
    .wr_row_i (new_row)
  );

  sacl_way_sel u_way_sel (
    .row_i (rd_row),
    .tag_i (tag_q),
    .dec_o (dec),
    .row_o (new_row)
  );

  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    evict_cnt_d = evict_cnt_q;
    if (rsp_o.valid && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (commit) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
      if (dec.hit) begin
        hit_cnt_d = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + CNT_W'(1);
      end else begin
        miss_cnt_d = (miss_cnt_q == '1) ? miss_cnt_q : miss_cnt_q + CNT_W'(1);
      end
      if (dec.evicted) begin
        evict_cnt_d = (evict_cnt_q == '1) ? evict_cnt_q : evict_cnt_q + CNT_W'(1);
      end
    end
    if (req_beat) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      evict_cnt_q <= evict_cnt_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (req_beat) begin
      set_q <= req_set;
      tag_q <= req_tag;
    end
    if (commit) begin
      out_hit_q     <= dec.hit;
      out_evicted_q <= dec.evicted;
      out_way_q     <= dec.way;
      out_set_q     <= set_q;
    end
  end

  // totals follow the counters, which only move on the beat being loaded
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.hit         = out_hit_q;
  assign rsp_o.evicted     = out_evicted_q;
  assign rsp_o.way         = OUT_WAY_W'(out_way_q);
  assign rsp_o.set_index   = OUT_SET_W'(out_set_q);
  assign rsp_o.hit_total   = hit_cnt_q;
  assign rsp_o.miss_total  = miss_cnt_q;
  assign rsp_o.evict_total = evict_cnt_q;

`ifndef NO_ASSERTIONS
  // a request beat starts a lookup that blocks the next one
  a_req_locks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_beat |=> busy_q && !req_i.ready)
    else $error("request taken while a lookup was not marked busy");

  // a set never holds the same tag in two valid ways
  a_unique_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> $onehot0(dec.match))
    else $error("tag matched in more than one valid way");

  // a hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_hit_q && out_evicted_q))
    else $error("response flags both hit and eviction");

  // a row write-back always lands a response in the output register
  a_wb_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q && !busy_q)
    else $error("write-back without a response");
`endif

endmodule

>>> tb/set_assoc_cache_lru_lookup_core_tb.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup_core_tb
// self-checking bench for the 4-way lru cache tag lookup
// ----------------------------------------------------------------------------
// a mirror of the tag, valid and lru state predicts hit, eviction, way, set
// and the running totals of every request beat. response beats are compared
// in order against those predictions. traffic is mostly aimed at a few sets
// with a few tags each, so hits, fills and lru evictions are all frequent.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sacl_pkg::*;

  localparam int unsigned RUN_LIMIT    = 400000;
  localparam int unsigned PHASE_ITEMS  = 630;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SET_POOL     = 6;
  localparam int unsigned TAG_POOL     = 7;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic                 hit;
    logic                 evicted;
    logic [OUT_WAY_W-1:0] way;
    logic [OUT_SET_W-1:0] set_index;
    cnt_t                 hit_total;
    cnt_t                 miss_total;
    cnt_t                 evict_total;
  } lookup_outcome_t;

  logic clk_i;
  logic rst_ni;

  sacl_req_if req_if ();
  sacl_rsp_if rsp_if ();

  set_assoc_cache_lru_lookup_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // mirror of the cache state
  tag_t  tag_mirror   [SETS][WAYS];
  logic  valid_mirror [SETS][WAYS];
  rank_t rank_mirror  [SETS][WAYS];
  cnt_t  hits_seen;
  cnt_t  misses_seen;
  cnt_t  evicts_seen;

  // addresses waiting to be offered, outcomes waiting to come back
  logic [IN_ADDR_W-1:0] address_q [$];
  lookup_outcome_t      outcome_q [$];

  int unsigned beats_queued;
  int unsigned beats_taken;
  int unsigned error_count;
  bit          req_beat_taken;

  // idling percentages, changed per phase
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // long receiver hold-off, requested once by the stimulus
  bit          hold_armed;
  bit          hold_done;
  int unsigned hold_left;

  set_idx_t set_pool [SET_POOL];
  tag_t     tag_pool [TAG_POOL];

  // --------------------------------------------------------------------------
  // predictor: tag compare over valid ways, first invalid way on a miss,
  // else the way of highest rank; used way gets rank 0 and younger ways age
  // --------------------------------------------------------------------------
  function automatic lookup_outcome_t predict_lookup(logic [IN_ADDR_W-1:0] addr);
    logic [ADDR_BITS-1:0] a;
    set_idx_t             s;
    tag_t                 t;
    way_t                 w;
    rank_t                old_rank;
    logic                 hit;
    logic                 found;
    logic                 evict;
    lookup_outcome_t      r;
    a     = addr[ADDR_BITS-1:0];
    s     = a[OFFSET_W +: SET_W];
    t     = a[OFFSET_W+SET_W +: TAG_W];
    w     = '0;
    hit   = 1'b0;
    found = 1'b0;
    evict = 1'b0;
    // an unwritten tag is never looked at since its valid bit is clear
    for (int i = 0; i < WAYS; i++) begin
      if (!hit && valid_mirror[s][i] && tag_mirror[s][i] == t) begin
        hit = 1'b1;
        w   = way_t'(i);
      end
    end
    if (hit) begin
      if (hits_seen != '1) hits_seen++;
    end else begin
      for (int i = 0; i < WAYS; i++) begin
        if (!found && !valid_mirror[s][i]) begin
          found = 1'b1;
          w     = way_t'(i);
        end
      end
      if (!found) begin
        for (int i = WAYS - 1; i >= 0; i--) begin
          if (rank_mirror[s][i] == rank_t'(WAYS - 1)) w = way_t'(i);
        end
        evict = 1'b1;
        if (evicts_seen != '1) evicts_seen++;
      end
      tag_mirror[s][w]   = t;
      valid_mirror[s][w] = 1'b1;
      if (misses_seen != '1) misses_seen++;
    end
    // recency update
    old_rank = rank_mirror[s][w];
    for (int i = 0; i < WAYS; i++) begin
      if (rank_mirror[s][i] < old_rank) rank_mirror[s][i]++;
    end
    rank_mirror[s][w] = '0;
    r.hit         = hit;
    r.evicted     = evict;
    r.way         = OUT_WAY_W'(w);
    r.set_index   = OUT_SET_W'(s);
    r.hit_total   = hits_seen;
    r.miss_total  = misses_seen;
    r.evict_total = evicts_seen;
    return r;
  endfunction

  task automatic note_error(string what, logic [31:0] want, logic [31:0] got);
    error_count++;
    if (error_count <= REPORT_LIMIT)
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endtask

  task automatic queue_access(logic [IN_ADDR_W-1:0] addr);
    address_q = {address_q, addr};
    beats_queued++;
  endtask

  // waits until every queued address was taken and every outcome returned;
  // the offset keeps it clear of the clocked processes
  task automatic wait_drain();
    do begin
      @(posedge clk_i);
      #1;
    end while (beats_taken != beats_queued || outcome_q.size() != 0);
  endtask

  // well-formed traffic hits a few sets with a few tags, so 4 ways overflow;
  // the rest is fully random noise
  function automatic logic [IN_ADDR_W-1:0] pick_address();
    logic [IN_ADDR_W-1:0] a;
    a = $urandom;
    if ($urandom_range(99) < 80) begin
      a[OFFSET_W +: SET_W]         = set_pool[$urandom_range(SET_POOL - 1)];
      a[OFFSET_W+SET_W +: TAG_W]   = tag_pool[$urandom_range(TAG_POOL - 1)];
    end
    return a;
  endfunction

  function automatic void refresh_pools();
    for (int i = 0; i < SET_POOL; i++) set_pool[i] = set_idx_t'($urandom);
    for (int i = 0; i < TAG_POOL; i++) tag_pool[i] = tag_t'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // request driver: holds a beat until taken, else offers the next address
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (req_if.valid && !req_beat_taken) begin
      // beat still waiting for ready
    end else if (address_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      req_if.valid   <= 1'b1;
      req_if.address <= address_q.pop_front();
    end else begin
      req_if.valid   <= 1'b0;
      req_if.address <= $urandom;
    end
  end

  // --------------------------------------------------------------------------
  // response ready: random stalls, plus one long hold-off counted here
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks response beats, predicts each accepted request beat
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    lookup_outcome_t want;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (outcome_q.size() == 0) begin
          note_error("unexpected response beat", '0, '1);
        end else begin
          want = outcome_q.pop_front();
          if (rsp_if.hit !== want.hit)
            note_error("hit", want.hit, rsp_if.hit);
          if (rsp_if.evicted !== want.evicted)
            note_error("evicted", want.evicted, rsp_if.evicted);
          if (rsp_if.way !== want.way)
            note_error("way", want.way, rsp_if.way);
          if (rsp_if.set_index !== want.set_index)
            note_error("set_index", want.set_index, rsp_if.set_index);
          if (rsp_if.hit_total !== want.hit_total)
            note_error("hit_total", want.hit_total, rsp_if.hit_total);
          if (rsp_if.miss_total !== want.miss_total)
            note_error("miss_total", want.miss_total, rsp_if.miss_total);
          if (rsp_if.evict_total !== want.evict_total)
            note_error("evict_total", want.evict_total, rsp_if.evict_total);
        end
      end
      req_beat_taken = req_if.valid && req_if.ready;
      if (req_beat_taken) begin
        outcome_q = {outcome_q, predict_lookup(req_if.address)};
        beats_taken++;
      end
    end else begin
      req_beat_taken = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // watchdog
  // --------------------------------------------------------------------------
  initial begin
    repeat (RUN_LIMIT) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    // known values on every input from time zero
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.address = '0;
    rsp_if.ready   = 1'b0;
    req_beat_taken = 1'b0;
    hold_armed     = 1'b0;
    hold_done      = 1'b0;
    hold_left      = 0;
    beats_queued   = 0;
    beats_taken    = 0;
    error_count    = 0;
    send_idle_pct  = 13;
    recv_idle_pct  = 66;
    hits_seen      = '0;
    misses_seen    = '0;
    evicts_seen    = '0;
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        tag_mirror[s][w]   = '0;
        valid_mirror[s][w] = 1'b0;
        rank_mirror[s][w]  = rank_t'(w);
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: address extremes, same block again, all-ones tag
    queue_access(32'h0000_0000);
    queue_access(32'hFFFF_FFFF);
    queue_access(32'h0000_003F);
    queue_access(32'hFFFF_FFC0);
    queue_access(32'hAAAA_AAAA);
    queue_access(32'h5555_5555);
    // fill set 5 with four tags, then reuse one and overflow the set
    queue_access(32'h0000_1140);
    queue_access(32'h0000_2140);
    queue_access(32'h0000_3140);
    queue_access(32'h0000_4140);
    queue_access(32'h0000_2155);   // hit on the second fill
    queue_access(32'h0000_5140);   // evicts the oldest way
    queue_access(32'h0000_1140);   // evicted tag comes back, evicts again
    queue_access(32'h0000_4140);   // hit on the least recently used way
    queue_access(32'h0000_6140);
    queue_access(32'h0000_2140);
    // a hit on the most recent way leaves the ranks alone
    queue_access(32'h0000_2140);
    // full set 63 with all-ones and all-zeros tags
    queue_access(32'h0000_0FC0);
    queue_access(32'h0000_1FC0);
    queue_access(32'h0000_2FC0);
    queue_access(32'h0000_3FC0);
    queue_access(32'hFFFF_FFFF);
    wait_drain();

    // random phases: sender idles lightly, then receiver, then nobody
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 13 : (p == 1) ? 66 : 0;
      recv_idle_pct = (p == 0) ? 66 : (p == 1) ? 13 : 0;
      refresh_pools();
      // the receiver stalls long while the sender keeps offering beats
      if (p == 2) hold_armed = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        queue_access(pick_address());
        // sender pause until every outstanding outcome has come back
        if (p == 0 && n == PHASE_ITEMS / 2) wait_drain();
      end
      wait_drain();
    end

    // a few more cycles to catch stray response beats
    repeat (8) @(posedge clk_i);
    #1;
    if (error_count == 0 && outcome_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
